### rtl/core/spq_pkg.sv
// Package for the sorted priority queue core: payload structs, operation
// and error codes, default sizes and the cell control struct.
// No dependencies.
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_BYTES_DEF = 8;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
  } spq_cmd_t;

  typedef struct packed {
    logic [63:0] top_key;
    logic        is_empty;
    logic [4:0]  entry_count;
    logic [1:0]  error_code;
  } spq_rsp_t;

  // Broadcast to every cell: at most one of these is set in a cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage

### rtl/core/spq_cell.sv
// One cell of the sorted chain: holds one key and decides each cycle whether
// to keep it, take the pushed key, or take a neighbor's key.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int KEY_W = 64,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  spq_ctrl_t        ctrl,
  input  logic [KEY_W-1:0] push_key,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] prev_key,
  input  logic             prev_ge,
  input  logic [KEY_W-1:0] next_key,
  output logic [KEY_W-1:0] key,
  output logic             ge
);

  logic             occupied;
  logic [KEY_W-1:0] key_next;

  assign occupied = (count > CNT_W'(IDX));
  // This cell's key stays in front of the pushed key.
  assign ge       = occupied && (key >= push_key);

  always_comb begin
    key_next = key;
    if (ctrl.push) begin
      if (ge) begin
        key_next = key;
      end else if (prev_ge) begin
        key_next = push_key;
      end else begin
        key_next = prev_key;
      end
    end else if (ctrl.pop) begin
      key_next = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

### rtl/core/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: command/response handshake, entry
// count, response register and the chain of spq_cell instances.
// Depends on spq_pkg and spq_cell.
//
//   Channel  Direction  Handshake            Payload
//   cmd      in         cmd_valid/cmd_stall  spq_cmd_t (operation, key)
//   rsp      out        rsp_valid/rsp_stall  spq_rsp_t (top_key, is_empty,
//                                            entry_count, error_code)
//
// Every command completes at the edge that accepts it: all cells update in
// parallel, each looking only at its two neighbors, and the response is
// registered at that same edge. One command per cycle is sustained while the
// response side keeps up; cmd_stall is high only while a response waits on
// rsp_stall. Reset clears the count and the response valid; the cell keys
// need no reset because only cells below the count are ever read.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  spq_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output spq_rsp_t rsp
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             is_full;
  logic             is_void;
  logic [1:0]       err;
  spq_ctrl_t        ctrl;
  logic [KEY_W-1:0] push_key;
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic             cell_ge  [DEPTH];
  logic [KEY_W-1:0] top_next;
  spq_rsp_t         rsp_next;

  // A new command is taken unless a response is still waiting downstream.
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_void  = (count == '0);
  // Only the leading KEY_BYTES bytes of the key are kept.
  assign push_key = cmd.key[63 -: KEY_W];

  always_comb begin
    ctrl       = '0;
    err        = ERR_OK;
    count_next = count;
    top_next   = cell_key[0];
    unique case (cmd.operation)
      OP_PUSH: begin
        if (is_full) begin
          err = ERR_FULL;
        end else begin
          ctrl.push  = accept;
          count_next = count + 1'b1;
          top_next   = cell_ge[0] ? cell_key[0] : push_key;
        end
      end
      OP_POP: begin
        if (is_void) begin
          err = ERR_EMPTY;
        end else begin
          ctrl.pop   = accept;
          count_next = count - 1'b1;
          top_next   = cell_key[1];
        end
      end
      default: begin
        // Peek, and the unused code that behaves as a peek.
        if (is_void) begin
          err = ERR_EMPTY;
        end
      end
    endcase
  end

  always_comb begin
    rsp_next.top_key     = (count_next != '0) ? (64'(top_next) << (64 - KEY_W)) : 64'd0;
    rsp_next.is_empty    = (count_next == '0);
    rsp_next.entry_count = 5'(count_next);
    rsp_next.error_code  = err;
  end

  // The chain: cell 0 holds the greatest key. A push moves smaller keys one
  // place down; a pop moves every key one place up.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic             prev_ge;
    logic [KEY_W-1:0] next_key;

    if (i == 0) begin : g_head
      assign prev_key = push_key;
      assign prev_ge  = 1'b1;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_ge  = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = cell_key[i];
    end else begin : g_link
      assign next_key = cell_key[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .KEY_W (KEY_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .push_key (push_key),
      .count    (count),
      .prev_key (prev_key),
      .prev_ge  (prev_ge),
      .next_key (next_key),
      .key      (cell_key[i]),
      .ge       (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
